[hdl/ebu_pkg.sv]
// ebu_pkg: shared types, widths and codes for the execution breakpoint unit.
// No dependencies; compile first.
package ebu_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int MODE_W          = 3;
    localparam int ADDR_W          = 16;
    localparam int CYC_W           = 16;
    localparam int STATUS_W        = 2;
    localparam int ENTRY_COUNT_W   = 5;
    localparam int EVENT_CNT_W     = 32;
    localparam int TOTAL_W         = 64;

    // command codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STEP   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ACK    = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HIT  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
        logic [CYC_W-1:0]  cpu_cycles;
        logic [CYC_W-1:0]  hw_cycles;
    } item_t;

    // one-cycle update requests from the sequencer to the statistics block
    typedef struct packed {
        logic              hit;
        logic              step;
        logic              ack;
        logic [ADDR_W-1:0] pc;
        logic [CYC_W-1:0]  cpu_cycles;
        logic [CYC_W-1:0]  hw_cycles;
    } stats_cmd_t;

    typedef struct packed {
        logic                   break_flag;
        logic [ADDR_W-1:0]      break_address;
        logic [EVENT_CNT_W-1:0] hit_count;
        logic [EVENT_CNT_W-1:0] step_count;
        logic [TOTAL_W-1:0]     cpu_cycle_total;
        logic [TOTAL_W-1:0]     hw_cycle_total;
    } stats_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        stats_t                   stats;
    } result_t;

endpackage

[hdl/ebu_if.sv]
// ebu_cmd_if / ebu_rsp_if: valid/ready channels carrying one command word
// and one result word. Depends on ebu_pkg.
interface ebu_cmd_if;
    import ebu_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [CYC_W-1:0]  cpu_cycles;
    logic [CYC_W-1:0]  hw_cycles;

    modport source (output valid, mode, address, cpu_cycles, hw_cycles, input ready);
    modport sink   (input valid, mode, address, cpu_cycles, hw_cycles, output ready);
endinterface

interface ebu_rsp_if;
    import ebu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     break_flag;
    logic [ADDR_W-1:0]        break_address;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic [EVENT_CNT_W-1:0]   hit_count;
    logic [EVENT_CNT_W-1:0]   step_count;
    logic [TOTAL_W-1:0]       cpu_cycle_total;
    logic [TOTAL_W-1:0]       hw_cycle_total;

    modport source (output valid, status, break_flag, break_address, entry_count,
                    hit_count, step_count, cpu_cycle_total, hw_cycle_total,
                    input ready);
    modport sink   (input valid, status, break_flag, break_address, entry_count,
                    hit_count, step_count, cpu_cycle_total, hw_cycle_total,
                    output ready);
endinterface

[hdl/execution_breakpoint_unit.sv]
// Execution breakpoint unit: one command word in, one result word out.
// Add, remove and check walk the table entry by entry through the single
// comparator and the one-read/one-write table port; a matching remove then
// moves the later entries down. Clear, step, ack and unused modes skip the walk.
// A new command is taken only after the result of the last one goes to the output
// register. rst_n is asynchronous, active low: table empty, break state and counters cleared.
module execution_breakpoint_unit #(
    parameter int MAX_ENTRIES = ebu_pkg::MAX_ENTRIES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    ebu_cmd_if.sink   cmd,
    ebu_rsp_if.source rsp
);
    import ebu_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    item_t               cmd_item;
    logic                seq_idle;
    logic                seq_report;
    logic [STATUS_W-1:0] seq_status;
    logic [CNT_W-1:0]    seq_count;
    logic                out_free;
    logic                cmd_accept;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0] mem_rdata;

    stats_cmd_t stats_cmd;
    stats_t     stats;

    // entry count is reported masked to the 5-bit field
    logic [CNT_W+ENTRY_COUNT_W-1:0] count_wide;

    result_t rsp_reg;
    logic    rsp_valid_reg;

    // ---------------------------------------------------------------
    // Command side: one word in flight, taken only while the
    // sequencer is idle.
    // ---------------------------------------------------------------
    assign cmd_item.mode       = cmd.mode;
    assign cmd_item.address    = cmd.address;
    assign cmd_item.cpu_cycles = cmd.cpu_cycles;
    assign cmd_item.hw_cycles  = cmd.hw_cycles;

    assign cmd.ready  = seq_idle;
    assign cmd_accept = cmd.valid && seq_idle;

    // ---------------------------------------------------------------
    // Result side: output register; the sequencer may hand over a new
    // word when it is empty or being drained this cycle.
    // ---------------------------------------------------------------
    assign out_free = !rsp_valid_reg || rsp.ready;

    ebu_seq #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd_accept),
        .item      (cmd_item),
        .out_free  (out_free),
        .idle      (seq_idle),
        .report    (seq_report),
        .status    (seq_status),
        .count     (seq_count),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .stats_cmd (stats_cmd)
    );

    // Breakpoint table storage
    ebu_bp_mem #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_bp_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Break latch and counters; updated in S_APPLY, before the result register captures them
    ebu_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stats_cmd),
        .stats (stats)
    );

    assign count_wide = {{ENTRY_COUNT_W{1'b0}}, seq_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (seq_report)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_report)
        begin
            rsp_reg.status      <= seq_status;
            rsp_reg.entry_count <= count_wide[ENTRY_COUNT_W-1:0];
            rsp_reg.stats       <= stats;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_reg.status;
    assign rsp.break_flag      = rsp_reg.stats.break_flag;
    assign rsp.break_address   = rsp_reg.stats.break_address;
    assign rsp.entry_count     = rsp_reg.entry_count;
    assign rsp.hit_count       = rsp_reg.stats.hit_count;
    assign rsp.step_count      = rsp_reg.stats.step_count;
    assign rsp.cpu_cycle_total = rsp_reg.stats.cpu_cycle_total;
    assign rsp.hw_cycle_total  = rsp_reg.stats.hw_cycle_total;

endmodule

[hdl/ebu_bp_mem.sv]
// ebu_bp_mem: breakpoint address table, one write and one registered read port.
// Depends on ebu_pkg.
module ebu_bp_mem #(
    parameter int MAX_ENTRIES = ebu_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [IDX_W-1:0]          waddr,
    input  logic [ebu_pkg::ADDR_W-1:0] wdata,
    input  logic                      re,
    input  logic [IDX_W-1:0]          raddr,
    output logic [ebu_pkg::ADDR_W-1:0] rdata
);
    import ebu_pkg::*;

    logic [ADDR_W-1:0] mem_reg [MAX_ENTRIES];
    logic [ADDR_W-1:0] rdata_reg;

    // contents undefined until written; only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ebu_stats.sv]
// ebu_stats: break latch, break PC and wrapping event/cycle counters.
// Depends on ebu_pkg.
module ebu_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  ebu_pkg::stats_cmd_t cmd,
    output ebu_pkg::stats_t     stats
);
    import ebu_pkg::*;

    stats_t stats_reg;
    stats_t stats_next;

    always_comb
    begin
        stats_next = stats_reg;
        if (cmd.hit)
        begin
            stats_next.break_flag    = 1'b1;
            stats_next.break_address = cmd.pc;
            stats_next.hit_count     = stats_reg.hit_count + EVENT_CNT_W'(1);
        end
        if (cmd.step)
        begin
            stats_next.step_count      = stats_reg.step_count + EVENT_CNT_W'(1);
            stats_next.cpu_cycle_total = stats_reg.cpu_cycle_total
                                       + TOTAL_W'(cmd.cpu_cycles);
            stats_next.hw_cycle_total  = stats_reg.hw_cycle_total
                                       + TOTAL_W'(cmd.hw_cycles);
        end
        if (cmd.ack)
        begin
            stats_next.break_flag = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

[hdl/ebu_seq.sv]
// ebu_seq: command sequencer; walks the table through one shared comparator,
// compacts it on remove and drives the statistics updates. Depends on ebu_pkg.
module ebu_seq #(
    parameter int MAX_ENTRIES = ebu_pkg::MAX_ENTRIES_DEF,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  ebu_pkg::item_t               item,
    input  logic                         out_free,
    output logic                         idle,
    output logic                         report,
    output logic [ebu_pkg::STATUS_W-1:0] status,
    output logic [CNT_W-1:0]             count,
    output logic                         mem_we,
    output logic [IDX_W-1:0]             mem_waddr,
    output logic [ebu_pkg::ADDR_W-1:0]   mem_wdata,
    output logic                         mem_re,
    output logic [IDX_W-1:0]             mem_raddr,
    input  logic [ebu_pkg::ADDR_W-1:0]   mem_rdata,
    output ebu_pkg::stats_cmd_t          stats_cmd
);
    import ebu_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_CMP    = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_MOVE   = 7'b0010000,
        S_APPLY  = 7'b0100000,
        S_REPORT = 7'b1000000
    } state_t;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W:0]      idx_plus;
    logic [CNT_W:0]      count_ext;

    assign idx_plus  = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign count_ext = {1'b0, count_reg};

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[IDX_W-1:0];
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = idx_reg[IDX_W-1:0];
        stats_cmd   = '0;
        stats_cmd.pc         = item_reg.address;
        stats_cmd.cpu_cycles = item_reg.cpu_cycles;
        stats_cmd.hw_cycles  = item_reg.hw_cycles;
        report      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    if (item.mode == MODE_ADD || item.mode == MODE_REMOVE
                        || item.mode == MODE_CHECK)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_SEARCH:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (mem_rdata == item_reg.address)
                begin
                    found_next = 1'b1;
                    state_next = (item_reg.mode == MODE_REMOVE) ? S_SHIFT : S_APPLY;
                end
                else
                begin
                    idx_next   = idx_plus[CNT_W-1:0];
                    state_next = S_SEARCH;
                end
            end
            S_SHIFT:
            begin
                // pull entry idx+1 down into idx while one remains behind
                if (idx_plus < count_ext)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_plus[IDX_W-1:0];
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_MOVE:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_plus[CNT_W-1:0];
                state_next = S_SHIFT;
            end
            S_APPLY:
            begin
                case (item_reg.mode)
                    MODE_ADD:
                    begin
                        if (!found_reg)
                        begin
                            if (count_reg >= MAX_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = item_reg.address;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    MODE_CLEAR:
                    begin
                        count_next = '0;
                    end
                    MODE_CHECK:
                    begin
                        if (found_reg)
                        begin
                            status_next   = ST_HIT;
                            stats_cmd.hit = 1'b1;
                        end
                    end
                    MODE_STEP:
                    begin
                        stats_cmd.step = 1'b1;
                    end
                    MODE_ACK:
                    begin
                        stats_cmd.ack = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    report     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign idle   = (state_reg == S_IDLE);
    assign status = status_reg;
    assign count  = count_reg;

endmodule

[hdl/ebu_checker.sv]
// ebu_checker: port-level assertions for execution_breakpoint_unit, with bind.
// Depends on ebu_pkg and execution_breakpoint_unit.
module ebu_checker #(
    parameter int MAX_ENTRIES = ebu_pkg::MAX_ENTRIES_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cmd_valid,
    input logic                                cmd_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [ebu_pkg::STATUS_W-1:0]        status,
    input logic                                break_flag,
    input logic [ebu_pkg::ENTRY_COUNT_W-1:0]   entry_count,
    input logic [ebu_pkg::EVENT_CNT_W-1:0]     hit_count
);
    import ebu_pkg::*;

    localparam logic [ENTRY_COUNT_W-1:0] MAX_MASKED = ENTRY_COUNT_W'(MAX_ENTRIES);

    // one command word at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(hit_count))
        else $error("stalled result word changed");

    a_hit_latches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_HIT |-> break_flag)
        else $error("hit reported without break flag");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> entry_count == MAX_MASKED)
        else $error("full reported below capacity");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (MAX_ENTRIES > 31) || (int'(entry_count) <= MAX_ENTRIES))
        else $error("entry count above capacity");

endmodule

bind execution_breakpoint_unit ebu_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
) u_ebu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .break_flag  (rsp.break_flag),
    .entry_count (rsp.entry_count),
    .hit_count   (rsp.hit_count)
);
